// ===== rtl/ril_pkg.sv =====
// shared constants and types for the rotatable indexed list
package ril_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int KIND_W     = 3;
    localparam int POS_W      = 7;
    localparam int AMT_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CNT_W:0]    t_sum;
    typedef logic [WORD_WIDTH-1:0] t_word;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROTATE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

// ===== rtl/ril_ram.sv =====
// generic simple dual-port ram with registered read
module ril_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ril_modulo.sv =====
// bit-serial remainder of an unsigned amount by the entry count
module ril_modulo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ril_pkg::AMT_W-1:0] i_dividend,
    input  ril_pkg::t_cnt             i_divisor,
    output logic                      o_done,
    output ril_pkg::t_cnt             o_rem
);

    logic                      r_busy;
    logic                      r_done;
    logic [$clog2(ril_pkg::AMT_W)-1:0] r_step;
    logic [ril_pkg::AMT_W-1:0] r_shift;
    ril_pkg::t_cnt             r_rem;
    ril_pkg::t_cnt             r_div;
    ril_pkg::t_cnt             n_trial;
    ril_pkg::t_cnt             n_rem;

    always_comb begin
        n_trial = {r_rem[ril_pkg::CNT_W-2:0], r_shift[ril_pkg::AMT_W-1]};
        n_rem   = (n_trial >= r_div) ? n_trial - r_div : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_shift <= i_dividend;
                r_rem   <= '0;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_shift <= {r_shift[ril_pkg::AMT_W-2:0], 1'b0};
                r_step  <= r_step + 1'b1;
                if (r_step == $bits(r_step)'(ril_pkg::AMT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/rotatable_indexed_list_core.sv =====
// rotatable indexed list: sequencer around one word ram
//
//  channel  | direction | tdata (low bit up)                      | tuser
//  s_axis   | in        | position[6:0] value[38:7] amount[54:39] | kind[2:0]
//  m_axis   | out       | read_word[31:0] count_now[38:32]        | status[1:0]
//
// one transaction at a time; get reads one ram word, rotate waits on the 16-step remainder unit,
// insert and remove move one entry per ram access, reverse makes four ram accesses per
// swapped pair, and errors go straight to the response state.
// synchronous active-low reset clears count, offset and control; ram contents are undefined.
// a finished result waits in the output register; the next item is taken once the sequencer
// is back in idle, and a stalled output only holds the sequencer in its response state.
module rotatable_indexed_list_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // position, value, rotate_amount, zero pad
    input  logic [ril_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [ril_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_word, count_now, zero pad
    output logic [ril_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [ril_pkg::STATUS_W-1:0]   m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_WRITE,
        ST_REM_SHIFT,
        ST_GET_WAIT,
        ST_ROT_WAIT,
        ST_REV_RA,
        ST_REV_RB,
        ST_REV_WA,
        ST_REV_WB,
        ST_RESP
    } t_state;

    t_state                       r_state;
    ril_pkg::t_cnt                r_count;
    ril_pkg::t_addr               r_off;
    ril_pkg::t_addr               r_cur;
    ril_pkg::t_addr               r_end;
    ril_pkg::t_word               r_word;
    logic                         r_bump;
    logic                         r_pend;
    ril_pkg::t_addr               r_pend_addr;
    logic                         r_neg;
    ril_pkg::t_addr               r_a;
    ril_pkg::t_addr               r_b;
    ril_pkg::t_addr               r_pair;
    ril_pkg::t_word               r_tmp;
    logic [ril_pkg::STATUS_W-1:0] r_res_status;
    ril_pkg::t_word               r_res_word;
    logic                         r_m_valid;
    logic [ril_pkg::STATUS_W-1:0] r_m_status;
    ril_pkg::t_word               r_m_word;
    ril_pkg::t_cnt                r_m_count;

    logic [ril_pkg::KIND_W-1:0]   in_kind;
    ril_pkg::t_cnt                in_pos;
    ril_pkg::t_word               in_value;
    logic [ril_pkg::AMT_W-1:0]    in_amt;
    logic [ril_pkg::AMT_W-1:0]    amt_abs;
    logic                         accept;

    ril_pkg::t_sum                slot_sum;
    ril_pkg::t_sum                slot_mod;
    ril_pkg::t_addr               slot;
    ril_pkg::t_sum                last_sum;
    ril_pkg::t_sum                last_mod;
    ril_pkg::t_addr               ins_p;
    logic                         ins_bump;

    ril_pkg::t_cnt                n_count_rem;
    ril_pkg::t_addr               n_off_dec;
    ril_pkg::t_addr               n_off_rem;
    ril_pkg::t_cnt                rot_r;
    ril_pkg::t_sum                rot_sum;
    ril_pkg::t_sum                rot_mod;
    ril_pkg::t_addr               n_a;
    ril_pkg::t_addr               n_b;
    logic                         out_free;

    logic                         ram_we;
    ril_pkg::t_addr               ram_waddr;
    ril_pkg::t_word               ram_wdata;
    ril_pkg::t_addr               ram_raddr;
    ril_pkg::t_word               ram_rdata;

    logic                         mod_start;
    logic                         mod_done;
    ril_pkg::t_cnt                mod_rem;

    assign in_kind  = s_axis_tuser;
    assign in_pos   = s_axis_tdata[6:0];
    assign in_value = s_axis_tdata[38:7];
    assign in_amt   = s_axis_tdata[54:39];
    assign amt_abs  = in_amt[ril_pkg::AMT_W-1] ? (~in_amt + 1'b1) : in_amt;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // logical index to physical slot
    always_comb begin
        slot_sum = ril_pkg::t_sum'(r_off) + ril_pkg::t_sum'(in_pos);
        slot_mod = (slot_sum >= ril_pkg::t_sum'(r_count))
                   ? slot_sum - ril_pkg::t_sum'(r_count) : slot_sum;
        slot     = slot_mod[ril_pkg::ADDR_W-1:0];

        last_sum = ril_pkg::t_sum'(r_off) + ril_pkg::t_sum'(r_count) - 1'b1;
        last_mod = (last_sum >= ril_pkg::t_sum'(r_count))
                   ? last_sum - ril_pkg::t_sum'(r_count) : last_sum;

        if (r_count == '0) begin
            ins_p    = '0;
            ins_bump = 1'b0;
        end else if (in_pos == r_count) begin
            ins_p    = (r_off == '0) ? r_count[ril_pkg::ADDR_W-1:0] : r_off;
            ins_bump = (r_off != '0);
        end else begin
            ins_p    = slot;
            ins_bump = (slot < r_off);
        end
    end

    // bookkeeping for remove, rotate and reverse
    always_comb begin
        n_count_rem = r_count - 1'b1;
        n_off_dec   = (r_end < r_off) ? r_off - 1'b1 : r_off;
        n_off_rem   = (ril_pkg::t_cnt'(n_off_dec) == n_count_rem) ? '0 : n_off_dec;

        rot_r   = (r_neg && mod_rem != '0) ? r_count - mod_rem : mod_rem;
        rot_sum = ril_pkg::t_sum'(r_off) + ril_pkg::t_sum'(rot_r);
        rot_mod = (rot_sum >= ril_pkg::t_sum'(r_count))
                  ? rot_sum - ril_pkg::t_sum'(r_count) : rot_sum;

        n_a = (ril_pkg::t_cnt'(r_a) + 1'b1 == r_count) ? '0 : r_a + 1'b1;
        n_b = (r_b == '0) ? n_count_rem[ril_pkg::ADDR_W-1:0] : r_b - 1'b1;
    end

    // ram port control
    always_comb begin
        ram_raddr = r_cur;
        ram_we    = r_pend;
        ram_waddr = r_pend_addr;
        ram_wdata = ram_rdata;
        case (r_state)
            ST_IDLE: begin
                ram_raddr = slot;
            end
            ST_INS_SHIFT: begin
                ram_raddr = r_cur - 1'b1;
            end
            ST_REM_SHIFT: begin
                ram_raddr = r_cur + 1'b1;
            end
            ST_INS_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_end;
                ram_wdata = r_word;
            end
            ST_REV_RA: begin
                ram_raddr = r_a;
            end
            ST_REV_RB: begin
                ram_raddr = r_b;
            end
            ST_REV_WA: begin
                ram_we    = 1'b1;
                ram_waddr = r_a;
                ram_wdata = ram_rdata;
            end
            ST_REV_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_b;
                ram_wdata = r_tmp;
            end
            default: begin
                ram_raddr = r_cur;
            end
        endcase
    end

    assign mod_start = accept && (in_kind == ril_pkg::KIND_ROTATE) && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_off     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_res_status <= ril_pkg::STATUS_OK;
                        r_res_word   <= '0;
                        r_state      <= ST_RESP;
                        case (in_kind)
                            ril_pkg::KIND_INSERT: begin
                                if (in_pos > r_count) begin
                                    r_res_status <= ril_pkg::STATUS_OOB;
                                end else if (r_count == ril_pkg::t_cnt'(ril_pkg::CAPACITY)) begin
                                    r_res_status <= ril_pkg::STATUS_FULL;
                                end else begin
                                    r_cur   <= r_count[ril_pkg::ADDR_W-1:0];
                                    r_end   <= ins_p;
                                    r_word  <= in_value;
                                    r_bump  <= ins_bump;
                                    r_state <= ST_INS_SHIFT;
                                end
                            end
                            ril_pkg::KIND_REMOVE: begin
                                if (in_pos >= r_count) begin
                                    r_res_status <= ril_pkg::STATUS_OOB;
                                end else begin
                                    r_cur   <= slot;
                                    r_end   <= slot;
                                    r_state <= ST_REM_SHIFT;
                                end
                            end
                            ril_pkg::KIND_GET: begin
                                if (in_pos >= r_count) begin
                                    r_res_status <= ril_pkg::STATUS_OOB;
                                end else begin
                                    r_state <= ST_GET_WAIT;
                                end
                            end
                            ril_pkg::KIND_ROTATE: begin
                                if (r_count != '0) begin
                                    r_neg   <= in_amt[ril_pkg::AMT_W-1];
                                    r_state <= ST_ROT_WAIT;
                                end
                            end
                            ril_pkg::KIND_REVERSE: begin
                                r_a    <= r_off;
                                r_b    <= last_mod[ril_pkg::ADDR_W-1:0];
                                r_pair <= r_count[ril_pkg::CNT_W-1:1];
                                if (r_count[ril_pkg::CNT_W-1:1] != '0) begin
                                    r_state <= ST_REV_RA;
                                end
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_INS_SHIFT: begin
                    if (r_cur != r_end) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_cur;
                        r_cur       <= r_cur - 1'b1;
                    end else begin
                        r_state <= ST_INS_WRITE;
                    end
                end
                ST_INS_WRITE: begin
                    r_count <= r_count + 1'b1;
                    if (r_bump) begin
                        r_off <= r_off + 1'b1;
                    end
                    r_state <= ST_RESP;
                end
                ST_REM_SHIFT: begin
                    if (ril_pkg::t_cnt'(r_cur) + 1'b1 < r_count) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_cur;
                        r_cur       <= r_cur + 1'b1;
                    end else begin
                        r_count <= n_count_rem;
                        r_off   <= n_off_rem;
                        r_state <= ST_RESP;
                    end
                end
                ST_GET_WAIT: begin
                    r_res_word <= ram_rdata;
                    r_state    <= ST_RESP;
                end
                ST_ROT_WAIT: begin
                    if (mod_done) begin
                        r_off   <= rot_mod[ril_pkg::ADDR_W-1:0];
                        r_state <= ST_RESP;
                    end
                end
                ST_REV_RA: begin
                    r_state <= ST_REV_RB;
                end
                ST_REV_RB: begin
                    r_tmp   <= ram_rdata;
                    r_state <= ST_REV_WA;
                end
                ST_REV_WA: begin
                    r_state <= ST_REV_WB;
                end
                ST_REV_WB: begin
                    r_a    <= n_a;
                    r_b    <= n_b;
                    r_pair <= r_pair - 1'b1;
                    r_state <= (r_pair == ril_pkg::t_addr'(1)) ? ST_RESP : ST_REV_RA;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_word   <= r_res_word;
                        r_m_count  <= r_count;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    ril_ram #(
        .WIDTH (ril_pkg::WORD_WIDTH),
        .DEPTH (ril_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ril_modulo u_modulo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (amt_abs),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_count, r_m_word};
    assign m_axis_tuser  = r_m_status;

endmodule

// ===== rtl/ril_checker.sv =====
// port-level checks for the rotatable indexed list, bound to the top level
module ril_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ril_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ril_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ril_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ril_pkg::STATUS_W-1:0]   m_axis_tuser
);

    // an accepted transaction is never followed by another in the next cycle
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // error results carry no read word
    a_err_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ril_pkg::STATUS_OK) |-> (m_axis_tdata[31:0] == '0))
        else $error("error result with nonzero read word");

    // full status only with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ril_pkg::STATUS_FULL)
        |-> (m_axis_tdata[38:32] == 7'(ril_pkg::CAPACITY)))
        else $error("full status with store not full");

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] <= 7'(ril_pkg::CAPACITY)))
        else $error("count above capacity");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind rotatable_indexed_list_core ril_checker u_ril_checker (.*);

// ===== test/rotatable_indexed_list_core_test.sv =====
// testbench for the rotatable indexed list core with a shadow copy of the list
`timescale 1ns / 1ps

typedef struct packed {
    logic [ril_pkg::STATUS_W-1:0] status;
    ril_pkg::t_word               word;
    ril_pkg::t_cnt                cnt;
} t_response;

class list_shadow;
    ril_pkg::t_word slots [ril_pkg::CAPACITY];
    ril_pkg::t_cnt  fill;
    ril_pkg::t_addr origin;
    t_response      awaited [$];
    int             errors;
    int             mismatches;

    function new();
        fill       = '0;
        origin     = '0;
        errors     = 0;
        mismatches = 0;
    endfunction

    function int slot_of(int idx);
        return (int'(origin) + idx) % int'(fill);
    endfunction

    function logic [ril_pkg::STATUS_W-1:0] do_insert(int idx, ril_pkg::t_word w);
        int  p;
        bit  bump;
        if (idx > int'(fill))
            return ril_pkg::STATUS_OOB;
        if (int'(fill) >= ril_pkg::CAPACITY)
            return ril_pkg::STATUS_FULL;
        if (fill == 0) begin
            p    = 0;
            bump = 1'b0;
        end else if (idx == int'(fill)) begin
            p    = (origin == 0) ? int'(fill) : int'(origin);
            bump = (origin != 0);
        end else begin
            p    = slot_of(idx);
            bump = (p < int'(origin));
        end
        for (int i = int'(fill); i > p; i--)
            slots[i] = slots[i-1];
        slots[p] = w;
        if (bump)
            origin = origin + 1'b1;
        fill = fill + 1'b1;
        return ril_pkg::STATUS_OK;
    endfunction

    function logic [ril_pkg::STATUS_W-1:0] do_remove(int idx);
        int p;
        if (idx >= int'(fill))
            return ril_pkg::STATUS_OOB;
        p = slot_of(idx);
        for (int i = p; i + 1 < int'(fill); i++)
            slots[i] = slots[i+1];
        if (p < int'(origin))
            origin = origin - 1'b1;
        fill = fill - 1'b1;
        if (fill == 0)
            origin = '0;
        else
            origin = ril_pkg::t_addr'(int'(origin) % int'(fill));
        return ril_pkg::STATUS_OK;
    endfunction

    function void do_rotate(logic signed [ril_pkg::AMT_W-1:0] amt);
        int r;
        if (fill == 0)
            return;
        // truncating remainder folded into 0..count-1
        r = int'(amt) % int'(fill);
        if (r < 0)
            r += int'(fill);
        origin = ril_pkg::t_addr'((int'(origin) + r) % int'(fill));
    endfunction

    function void do_reverse();
        int             a;
        int             b;
        ril_pkg::t_word t;
        for (int i = 0; i < int'(fill) / 2; i++) begin
            a        = slot_of(i);
            b        = slot_of(int'(fill) - 1 - i);
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        end
    endfunction

    function void note_request(logic [ril_pkg::KIND_W-1:0] kind,
                               logic [ril_pkg::POS_W-1:0] pos, ril_pkg::t_word val,
                               logic signed [ril_pkg::AMT_W-1:0] amt);
        t_response r;
        r = '0;
        case (kind)
            ril_pkg::KIND_INSERT:  r.status = do_insert(int'(pos), val);
            ril_pkg::KIND_REMOVE:  r.status = do_remove(int'(pos));
            ril_pkg::KIND_GET: begin
                if (int'(pos) >= int'(fill))
                    r.status = ril_pkg::STATUS_OOB;
                else
                    r.word = slots[slot_of(int'(pos))];
            end
            ril_pkg::KIND_ROTATE:  do_rotate(amt);
            ril_pkg::KIND_REVERSE: do_reverse();
            default: ;
        endcase
        r.cnt = fill;
        awaited.push_back(r);
    endfunction

    function void check_response(logic [ril_pkg::STATUS_W-1:0] status, ril_pkg::t_word word,
                                 ril_pkg::t_cnt cnt);
        t_response e;
        if (awaited.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: status %0d word %h count %0d",
                         status, word, cnt);
            return;
        end
        e = awaited.pop_front();
        if (e.status !== status || e.word !== word || e.cnt !== cnt) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected status %0d word %h count %0d, got %0d %h %0d",
                         e.status, e.word, e.cnt, status, word, cnt);
        end
    endfunction
endclass

module rotatable_indexed_list_core_test;

    localparam logic [ril_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [ril_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int RANDOM_ITEMS = 1800;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ril_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ril_pkg::KIND_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ril_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [ril_pkg::STATUS_W-1:0]   m_axis_tuser;

    bit         calm = 1'b0;
    list_shadow shadow = new();

    rotatable_indexed_list_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_response(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]);
    end

    task automatic send_op(logic [ril_pkg::KIND_W-1:0] kind, logic [ril_pkg::POS_W-1:0] pos,
                           ril_pkg::t_word val, logic signed [ril_pkg::AMT_W-1:0] amt);
        while (!calm && $urandom_range(99) < 35) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {1'b0, amt, val, pos};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        shadow.note_request(kind, pos, val, amt);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [ril_pkg::KIND_W-1:0] pick_kind(int mode);
        int          r;
        int unsigned k;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                if (r < 76)      return ril_pkg::KIND_INSERT;
                else if (r < 79) return ril_pkg::KIND_REMOVE;
                else if (r < 89) return ril_pkg::KIND_GET;
            end
            MODE_DRAIN: begin
                if (r < 10)      return ril_pkg::KIND_INSERT;
                else if (r < 65) return ril_pkg::KIND_REMOVE;
                else if (r < 80) return ril_pkg::KIND_GET;
            end
            default: begin
                if (r < 30)      return ril_pkg::KIND_INSERT;
                else if (r < 55) return ril_pkg::KIND_REMOVE;
                else if (r < 80) return ril_pkg::KIND_GET;
            end
        endcase
        r = $urandom_range(99);
        if (r < 55)      return ril_pkg::KIND_ROTATE;
        else if (r < 90) return ril_pkg::KIND_REVERSE;
        k = KIND_SPARE_LO + $urandom_range(KIND_SPARE_HI - KIND_SPARE_LO);
        return k[ril_pkg::KIND_W-1:0];
    endfunction

    function automatic logic [ril_pkg::POS_W-1:0] pick_position();
        int unsigned p;
        if ($urandom_range(99) < 88)
            p = $urandom_range(int'(shadow.fill), 0);
        else
            p = $urandom_range(127);
        return p[ril_pkg::POS_W-1:0];
    endfunction

    function automatic logic signed [ril_pkg::AMT_W-1:0] pick_amount();
        int unsigned a;
        if ($urandom_range(1))
            a = $urandom_range(140) - 70;
        else
            a = $urandom_range(16'hFFFF);
        return a[ril_pkg::AMT_W-1:0];
    endfunction

    initial begin
        int mode;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty list corner cases
        send_op(ril_pkg::KIND_GET,     7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_REMOVE,  7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_ROTATE,  7'd0,  '0, 16'sd5);
        send_op(ril_pkg::KIND_REVERSE, 7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_INSERT,  7'd1,  32'hDEADBEEF, 16'sd0);
        // build a short list, appending with zero and nonzero offset
        send_op(ril_pkg::KIND_INSERT,  7'd0,  32'hFFFFFFFF, 16'sd0);
        send_op(ril_pkg::KIND_INSERT,  7'd1,  32'h00000000, 16'sd0);
        send_op(ril_pkg::KIND_INSERT,  7'd0,  32'hA5A5A5A5, 16'sd0);
        send_op(ril_pkg::KIND_INSERT,  7'd1,  32'h5A5A5A5A, 16'sd0);
        send_op(ril_pkg::KIND_ROTATE,  7'd0,  '0, 16'sd1);
        send_op(ril_pkg::KIND_INSERT,  7'd4,  32'h12345678, 16'sd0);
        send_op(ril_pkg::KIND_INSERT,  7'd7,  32'h87654321, 16'sd0);
        send_op(ril_pkg::KIND_ROTATE,  7'd0,  '0, 16'sh8000);
        send_op(ril_pkg::KIND_ROTATE,  7'd0,  '0, 16'sd32767);
        send_op(ril_pkg::KIND_REVERSE, 7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_GET,     7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_GET,     7'd4,  '0, 16'sd0);
        send_op(ril_pkg::KIND_GET,     7'd64, '0, 16'sd0);
        send_op(KIND_SPARE_LO, 7'd127, 32'hFFFFFFFF, -16'sd1);
        send_op(KIND_SPARE_HI, 7'd0,  '0, 16'sd0);
        send_op(ril_pkg::KIND_REMOVE,  7'd2,  '0, 16'sd0);
        // drain to empty so the offset returns to zero
        repeat (4) send_op(ril_pkg::KIND_REMOVE, 7'd0, '0, 16'sd0);
        send_op(ril_pkg::KIND_GET,     7'd0,  '0, 16'sd0);

        mode = MODE_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n > 0 && n % 100 == 0)
                mode = $urandom_range(MODE_MIXED);
            calm = (n >= 700 && n < 1000);
            send_op(pick_kind(mode), pick_position(), $urandom(), pick_amount());
        end
        calm = 1'b0;

        while (shadow.awaited.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        shadow.errors += shadow.awaited.size();
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
